// File: rtl/core/mh64_pkg.sv
// Package with the shared constants, sequencer states and helpers of the MurmurHash64A block.
package mh64_pkg;

    localparam logic [63:0] MUR_M      = 64'hc6a4a7935bd1e995;
    localparam int unsigned MUR_R      = 47;
    localparam logic [31:0] SEED_RESET = 32'd5;

    localparam int unsigned LEN_W   = 31;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned TDATA_W = 104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DISPATCH,
        ST_K1,
        ST_K2,
        ST_HM,
        ST_FIN
    } mh64_state_t;

    // Keeps the low count bytes of a word, for a tail of 1 to 7 bytes.
    function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
        logic [63:0] m;
        unique case (cnt)
            3'd1:    m = 64'h0000_0000_0000_00ff;
            3'd2:    m = 64'h0000_0000_0000_ffff;
            3'd3:    m = 64'h0000_0000_00ff_ffff;
            3'd4:    m = 64'h0000_0000_ffff_ffff;
            3'd5:    m = 64'h0000_00ff_ffff_ffff;
            3'd6:    m = 64'h0000_ffff_ffff_ffff;
            3'd7:    m = 64'h00ff_ffff_ffff_ffff;
            default: m = 64'h0;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MUR_R);
    endfunction

endpackage

// File: rtl/core/murmur64a_hash_stream_top.sv
// Streaming MurmurHash64A engine built around one shared 32x32 multiplier.
// Each 64-bit multiply by m runs in phases: three partial products on the shared
// multiplier, each registered, then accumulated. A word is accepted in idle and
// dispatched, then runs the K1, K2 and HM multiplies for a full word or only HM for a
// tail, plus the length multiply on a first word and the finalization multiply on a last.
// Reset (aresetn low at a clock edge) empties the block and sets the seed to 5.
module murmur64a_hash_stream_top
    import mh64_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,   // seed

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [30:0] msg_len, [94:31] data_word, [98:95] byte_count, [103:99] zero
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic                 s_tlast,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata        // [63:0] hash
);

    mh64_state_t       state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic              in_msg_reg, in_msg_next;
    logic [31:0]       seed_reg;
    logic [63:0]       h_reg, h_next;
    logic [63:0]       op_reg, op_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       prod_reg;
    logic [63:0]       word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_reg, out_next;

    logic              in_accept;
    logic              mul_state;
    logic              out_free;
    logic              mul_done;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_res;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign mul_state = (state_reg == ST_INIT) || (state_reg == ST_K1) ||
                       (state_reg == ST_K2) || (state_reg == ST_HM) ||
                       (state_reg == ST_FIN);
    // Finalization waits in its last phase until the output register is free.
    assign mul_done  = mul_state && (phase_reg == 2'd3) &&
                       ((state_reg != ST_FIN) || out_free);

    // Low 64 bits of op * m: lo*mlo + ((hi*mlo + lo*mhi) << 32).
    // The last phase repeats the lo*mhi product so that a stall keeps it intact.
    always_comb begin
        unique case (phase_reg)
            2'd1: begin
                mul_a = op_reg[63:32];
                mul_b = MUR_M[31:0];
            end
            2'd2, 2'd3: begin
                mul_a = op_reg[31:0];
                mul_b = MUR_M[63:32];
            end
            default: begin
                mul_a = op_reg[31:0];
                mul_b = MUR_M[31:0];
            end
        endcase
    end

    assign mul_res = acc_reg + {prod_reg[31:0], 32'd0};

    always_comb begin
        unique case (phase_reg)
            2'd1:    acc_next = prod_reg;
            2'd2:    acc_next = mul_res;
            default: acc_next = acc_reg;
        endcase
        if (!mul_state) begin
            phase_next = 2'd0;
        end else if (phase_reg != 2'd3) begin
            phase_next = phase_reg + 2'd1;
        end else if (mul_done) begin
            phase_next = 2'd0;
        end else begin
            phase_next = phase_reg;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = in_msg_reg ? ST_DISPATCH : ST_INIT;
                end
            end
            ST_INIT: begin
                if (mul_done) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (cnt_reg[3]) begin
                    state_next = ST_K1;
                end else if (cnt_reg[2:0] != 3'd0) begin
                    state_next = ST_HM;
                end else if (last_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_K1: begin
                if (mul_done) begin
                    state_next = ST_K2;
                end
            end
            ST_K2: begin
                if (mul_done) begin
                    state_next = ST_HM;
                end
            end
            ST_HM: begin
                if (mul_done) begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (mul_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        h_next         = h_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        in_msg_next    = in_msg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    word_next = s_tdata[LEN_W +: WORD_W];
                    cnt_next  = s_tdata[LEN_W + WORD_W +: CNT_W];
                    last_next = s_tlast;
                    op_next   = {{(64 - LEN_W){1'b0}}, s_tdata[LEN_W-1:0]};
                end
            end
            ST_INIT: begin
                if (mul_done) begin
                    h_next = {32'd0, seed_reg} ^ mul_res;
                end
            end
            ST_DISPATCH: begin
                priority if (cnt_reg[3]) begin
                    op_next = word_reg;
                end else if (cnt_reg[2:0] != 3'd0) begin
                    op_next = h_reg ^ (word_reg & tail_mask(cnt_reg[2:0]));
                end else if (last_reg) begin
                    op_next = xor_shift(h_reg);
                end else begin
                    in_msg_next = 1'b1;
                end
            end
            ST_K1: begin
                if (mul_done) begin
                    op_next = xor_shift(mul_res);
                end
            end
            ST_K2: begin
                if (mul_done) begin
                    op_next = h_reg ^ mul_res;
                end
            end
            ST_HM: begin
                if (mul_done) begin
                    h_next  = mul_res;
                    op_next = xor_shift(mul_res);
                    if (!last_reg) begin
                        in_msg_next = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (mul_done) begin
                    out_next       = xor_shift(mul_res);
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    h_next         = 64'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 2'd0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_a * mul_b;
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

endmodule

// File: rtl/core/mh64_checker.sv
// Port-level checker for the MurmurHash64A engine, bound to its top level.
module mh64_checker
    import mh64_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [63:0]        m_tdata
);

    // A waiting hash word holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed or dropped while stalled");

    // The engine is busy on the cycle after it takes a word.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // An accepted word cannot raise the hash valid before it has gone through dispatch.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
        else $error("hash appeared too soon after an input word");

    // Reset leaves the engine empty and ready.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("engine not empty after reset");

endmodule

bind murmur64a_hash_stream_top mh64_checker u_mh64_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/murmur_hash_checker.sv
// Checker for the MurmurHash64A stream block: predicts each hash and compares it with the output.
module murmur_hash_checker
    import mh64_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [63:0]        m_tdata,
    output int                 mismatches,
    output int                 hashes_due
);

    localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;
    localparam logic [31:0] SEED_INIT = 32'd5;

    logic [31:0] seed_r;
    logic [63:0] run_hash;
    logic        in_msg;
    logic [63:0] hash_due_q[$];

    function automatic logic [63:0] mix_block(input logic [63:0] h, input logic [63:0] k);
        logic [63:0] t;
        t = k * MIX_MULT;
        t = t ^ (t >> MIX_SHIFT);
        t = t * MIX_MULT;
        return (h ^ t) * MIX_MULT;
    endfunction

    function automatic logic [63:0] mix_tail(input logic [63:0] h, input logic [63:0] w,
                                             input logic [3:0] cnt);
        int unsigned nbits;
        logic [63:0] keep;
        nbits = 8 * int'(cnt);
        keep  = (64'd1 << nbits) - 64'd1;
        return (h ^ (w & keep)) * MIX_MULT;
    endfunction

    function automatic logic [63:0] finish_hash(input logic [63:0] h);
        logic [63:0] t;
        t = h ^ (h >> MIX_SHIFT);
        t = t * MIX_MULT;
        return t ^ (t >> MIX_SHIFT);
    endfunction

    always @(posedge aclk) begin : watch
        logic [30:0] len;
        logic [63:0] word;
        logic [3:0]  cnt;
        logic [63:0] h;
        logic [63:0] want;
        if (!aresetn) begin
            seed_r   = SEED_INIT;
            run_hash = '0;
            in_msg   = 1'b0;
            hash_due_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                len  = s_tdata[30:0];
                word = s_tdata[94:31];
                cnt  = s_tdata[98:95];
                if (!in_msg) begin
                    run_hash = {32'd0, seed_r} ^ ({33'd0, len} * MIX_MULT);
                end
                h = run_hash;
                // Counts above eight saturate to a full block.
                if (cnt >= 4'd8) begin
                    h = mix_block(h, word);
                end else if (cnt != 4'd0) begin
                    h = mix_tail(h, word, cnt);
                end
                if (s_tlast) begin
                    hash_due_q.push_back(finish_hash(h));
                    run_hash = '0;
                    in_msg   = 1'b0;
                end else begin
                    run_hash = h;
                    in_msg   = 1'b1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (hash_due_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected hash word %h", m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = hash_due_q.pop_front();
                    if (m_tdata !== want) begin
                        if (mismatches < 10) begin
                            $display("hash mismatch: expected %h, got %h", want, m_tdata);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en) begin
                seed_r = cfg_wr_data;
            end
        end
        hashes_due = hash_due_q.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the MurmurHash64A stream block: clock, reset, stimulus and verdict.
module tb;
    import mh64_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // [30:0] msg_len, [94:31] data_word, [98:95] byte_count
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [63:0]        m_tdata;   // [63:0] hash

    int mismatches;
    int hashes_due;
    int items_sent;
    bit calm;

    murmur64a_hash_stream_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    murmur_hash_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .hashes_due  (hashes_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Mostly zero, sometimes short, rarely a long pause; always zero while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic push_word(input logic [30:0] len, input logic [63:0] word,
                             input logic [3:0] cnt, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, cnt, word, len};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Drops valid and waits until every hash is out and the engine has drained.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (hashes_due == 0);
        repeat (40) @(negedge aclk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_message(input int nbytes, input logic [30:0] len_field);
        int full;
        int rest;
        full = nbytes / 8;
        rest = nbytes % 8;
        if (nbytes == 0) begin
            push_word(len_field, rand_word(), 4'd0, 1'b1);
        end else begin
            for (int i = 0; i < full; i++) begin
                push_word(len_field, rand_word(), 4'd8, (rest == 0) && (i == full - 1));
            end
            if (rest != 0) begin
                push_word(len_field, rand_word(), 4'(rest), 1'b1);
            end
        end
    endtask

    // Arbitrary byte counts on every word, including zero, partial and above eight.
    task automatic send_broken();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            push_word(31'($urandom), rand_word(), 4'($urandom_range(0, 15)), i == n - 1);
        end
    endtask

    task automatic random_phase(input int quota);
        int stop_at;
        int r;
        int nbytes;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                calm = !calm;
            end
            r = $urandom_range(0, 99);
            if (r < 15) begin
                send_broken();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    nbytes = $urandom_range(0, 24);
                end else if (r < 95) begin
                    nbytes = $urandom_range(25, 80);
                end else begin
                    nbytes = $urandom_range(81, 300);
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_message(nbytes, 31'($urandom));
                end else begin
                    send_message(nbytes, 31'(nbytes));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        items_sent  = 0;
        calm        = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Seed left at its reset value.
        push_word(31'd0, rand_word(), 4'd0, 1'b1);
        push_word(31'h7fffffff, '1, 4'd8, 1'b1);
        push_word(31'd8, 64'd0, 4'd8, 1'b1);
        // Tails of one to seven bytes; the unused bytes are all ones and must be masked.
        for (int c = 1; c < 8; c++) begin
            push_word(31'(c), '1, 4'(c), 1'b1);
        end

        load_seed(32'hffffffff);
        push_word(31'd16, rand_word(), 4'd8, 1'b0);
        push_word(31'd16, '1, 4'd15, 1'b1);
        // Length mismatch, zero-count word and a partial word in mid-message.
        push_word(31'd0, rand_word(), 4'd9, 1'b0);
        push_word(31'd0, rand_word(), 4'd12, 1'b0);
        push_word(31'd0, rand_word(), 4'd0, 1'b0);
        push_word(31'd0, rand_word(), 4'd3, 1'b0);
        push_word(31'd0, rand_word(), 4'd10, 1'b1);

        load_seed(32'd0);
        push_word(31'd0, 64'd0, 4'd0, 1'b1);
        push_word(31'h7fffffff, rand_word(), 4'd8, 1'b0);
        push_word(31'h7fffffff, rand_word(), 4'd7, 1'b1);

        load_seed(32'hffffffff);
        random_phase(490);
        load_seed(32'd0);
        random_phase(490);
        load_seed($urandom);
        random_phase(490);
        load_seed($urandom);
        random_phase(490);

        settle();
        @(negedge aclk);
        if (mismatches == 0 && hashes_due == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mh64_pkg.sv
rtl/core/murmur64a_hash_stream_top.sv
rtl/core/mh64_checker.sv
tb/murmur_hash_checker.sv
tb/tb.sv
